// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int RAW_W        = 20;
    localparam int RAW_BITS_DEF = 20;
    localparam int DW           = 64;
    localparam int TW           = 32;
    localparam int CAL_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int TCAL_W       = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 2'd3;

    localparam logic [DW-1:0] FINE_OFFSET = 64'd128000;
    localparam logic [DW-1:0] NUM_SCALE   = 64'd3125;
    localparam logic [DW-1:0] PRESS_BASE  = 64'd1048576;
    localparam logic [DW-1:0] V1_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [TW-1:0] TEMP_ROUND  = 32'd128;
    localparam logic [DW-1:0] DIV256_BIAS = 64'd255;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_A,
        ST_T_D,
        ST_T_E,
        ST_P_S,
        ST_P_V2A,
        ST_P_T,
        ST_P_U,
        ST_P_W,
        ST_P_V1C,
        ST_P_NUM,
        ST_P_DIV,
        ST_P_F,
        ST_P_G,
        ST_P_H,
        ST_P_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } t_div_req;

    function automatic logic [DW-1:0] sext16(input logic [CAL_W-1:0] w);
        return {{(DW-CAL_W){w[CAL_W-1]}}, w};
    endfunction

endpackage

// ===== rtl/bsc_mul.sv =====
// ----------------------------------------------------------------------------
// bsc_mul
// Bit-serial 64-bit multiplier, low 64 bits of the product, one bit a cycle.
// ----------------------------------------------------------------------------
module bsc_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsc_pkg::t_mul_req         i_req,
    output logic                      o_done,
    output logic [bsc_pkg::DW-1:0]    o_product
);

    localparam int CW = $clog2(bsc_pkg::DW + 1);

    logic [bsc_pkg::DW-1:0] r_a, r_b, r_acc;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= CW'(bsc_pkg::DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== rtl/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div
// Restoring unsigned 64-bit divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bsc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsc_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [bsc_pkg::DW-1:0]    o_quotient
);

    localparam int CW = $clog2(bsc_pkg::DW + 1);

    logic [bsc_pkg::DW-1:0] r_rem, r_quo, r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy, r_done;
    logic [bsc_pkg::DW:0]   shifted, diff;

    assign shifted = {r_rem, r_quo[bsc_pkg::DW-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= CW'(bsc_pkg::DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // keep the difference when no borrow
                if (!diff[bsc_pkg::DW]) begin
                    r_rem <= diff[bsc_pkg::DW-1:0];
                end else begin
                    r_rem <= shifted[bsc_pkg::DW-1:0];
                end
                r_quo <= {r_quo[bsc_pkg::DW-2:0], ~diff[bsc_pkg::DW]};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Each step runs one serial multiply or divide, plus launch and capture. A
// temperature item runs only multiply steps; a pressure item whose divisor is
// zero ends after the step that forms the divisor (ST_P_V1C), before the divide.
// The block handles one item at a time; the serial multiplier sets its pace.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears calibration, fine temperature and control.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation around a shared serial
// multiplier and a serial divider.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation #(
    parameter int RAW_BITS = bsc_pkg::RAW_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bsc_pkg::DW-1:0]            i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [bsc_pkg::RAW_W-1:0]         i_raw_reading,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [bsc_pkg::TW-1:0]     o_temperature_centi,
    output logic [bsc_pkg::TW-1:0]            o_pressure_pa,
    output logic                              o_zero_divisor
);

    localparam int DW = bsc_pkg::DW;
    localparam int TW = bsc_pkg::TW;

    bsc_pkg::t_state r_state, n_state;

    logic [bsc_pkg::TCAL_W-1:0] r_tcal;
    logic [DW-1:0]              r_pcal_lo, r_pcal_hi;
    logic [bsc_pkg::CAL_W-1:0]  r_pcal_last;
    logic [TW-1:0]              r_fine;
    logic [RAW_BITS-1:0]        r_adc;
    logic                       r_op, r_launched, r_rz, r_ov;
    logic [DW-1:0]              r_x, r_y, r_s, r_p;
    logic [TW-1:0]              r_rt;
    logic [TW-1:0]              r_o_temp, r_o_press;
    logic                       r_o_zd;

    bsc_pkg::t_mul_req mul_req;
    bsc_pkg::t_div_req div_req;
    logic              mul_done, div_done;
    logic [DW-1:0]     pr, quo;

    logic [bsc_pkg::RAW_W-1:0] adc20;
    logic [TW-1:0]             ta, td, fine_n, f5, temp_n;
    logic [DW-1:0]             v1, e, v1c, p0, numer, qs, pfin, p_biased;
    logic                      is_mul;

    bsc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (pr)
    );

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // derived operands
    assign adc20  = bsc_pkg::RAW_W'(r_adc) << (bsc_pkg::RAW_W - RAW_BITS);
    assign ta     = TW'(adc20 >> 3) - TW'({r_tcal[15:0], 1'b0});
    assign td     = TW'(adc20 >> 4) - TW'(r_tcal[15:0]);
    assign fine_n = r_x[TW-1:0] + TW'($signed(pr[TW-1:0]) >>> 14);
    assign f5     = (fine_n << 2) + fine_n + bsc_pkg::TEMP_ROUND;
    assign temp_n = TW'($signed(f5) >>> 8);
    assign v1     = {{(DW-TW){r_fine[TW-1]}}, r_fine} - bsc_pkg::FINE_OFFSET;
    assign e      = DW'($signed(r_p) >>> 13);
    assign v1c    = DW'($signed(pr) >>> 33);
    assign p0     = bsc_pkg::PRESS_BASE - DW'(adc20);
    assign numer  = (p0 << 31) - r_x;
    assign qs     = (r_x[DW-1] ^ r_y[DW-1]) ? (DW'(0) - quo) : quo;
    assign pfin   = DW'($signed(r_p + r_y + r_x) >>> 8)
                    + (bsc_pkg::sext16(r_pcal_hi[47:32]) << 4);
    assign p_biased = r_x + (r_x[DW-1] ? bsc_pkg::DIV256_BIAS : DW'(0));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_opcode ? bsc_pkg::ST_P_S : bsc_pkg::ST_T_A;
                end
            end
            bsc_pkg::ST_T_A:   if (mul_done) n_state = bsc_pkg::ST_T_D;
            bsc_pkg::ST_T_D:   if (mul_done) n_state = bsc_pkg::ST_T_E;
            bsc_pkg::ST_T_E:   if (mul_done) n_state = bsc_pkg::ST_OUT;
            bsc_pkg::ST_P_S:   if (mul_done) n_state = bsc_pkg::ST_P_V2A;
            bsc_pkg::ST_P_V2A: if (mul_done) n_state = bsc_pkg::ST_P_T;
            bsc_pkg::ST_P_T:   if (mul_done) n_state = bsc_pkg::ST_P_U;
            bsc_pkg::ST_P_U:   if (mul_done) n_state = bsc_pkg::ST_P_W;
            bsc_pkg::ST_P_W:   if (mul_done) n_state = bsc_pkg::ST_P_V1C;
            bsc_pkg::ST_P_V1C: begin
                if (mul_done) begin
                    n_state = (v1c == '0) ? bsc_pkg::ST_OUT : bsc_pkg::ST_P_NUM;
                end
            end
            bsc_pkg::ST_P_NUM: if (mul_done) n_state = bsc_pkg::ST_P_DIV;
            bsc_pkg::ST_P_DIV: if (div_done) n_state = bsc_pkg::ST_P_F;
            bsc_pkg::ST_P_F:   if (mul_done) n_state = bsc_pkg::ST_P_G;
            bsc_pkg::ST_P_G:   if (mul_done) n_state = bsc_pkg::ST_P_H;
            bsc_pkg::ST_P_H:   if (mul_done) n_state = bsc_pkg::ST_P_SUM;
            bsc_pkg::ST_P_SUM: n_state = bsc_pkg::ST_OUT;
            bsc_pkg::ST_OUT: begin
                if (!r_ov || i_ready) begin
                    n_state = bsc_pkg::ST_IDLE;
                end
            end
            default: n_state = bsc_pkg::ST_IDLE;
        endcase
    end

    // unit requests
    always_comb begin
        is_mul    = 1'b1;
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (r_state)
            bsc_pkg::ST_T_A: begin
                mul_req.a = DW'(ta);
                mul_req.b = bsc_pkg::sext16(r_tcal[31:16]);
            end
            bsc_pkg::ST_T_D: begin
                mul_req.a = DW'(td);
                mul_req.b = DW'(td);
            end
            bsc_pkg::ST_T_E: begin
                mul_req.a = r_y;
                mul_req.b = bsc_pkg::sext16(r_tcal[47:32]);
            end
            bsc_pkg::ST_P_S: begin
                mul_req.a = v1;
                mul_req.b = v1;
            end
            bsc_pkg::ST_P_V2A: begin
                mul_req.a = r_s;
                mul_req.b = bsc_pkg::sext16(r_pcal_hi[31:16]);
            end
            bsc_pkg::ST_P_T: begin
                mul_req.a = v1;
                mul_req.b = bsc_pkg::sext16(r_pcal_hi[15:0]);
            end
            bsc_pkg::ST_P_U: begin
                mul_req.a = r_s;
                mul_req.b = bsc_pkg::sext16(r_pcal_lo[47:32]);
            end
            bsc_pkg::ST_P_W: begin
                mul_req.a = v1;
                mul_req.b = bsc_pkg::sext16(r_pcal_lo[31:16]);
            end
            bsc_pkg::ST_P_V1C: begin
                mul_req.a = r_y;
                mul_req.b = DW'(r_pcal_lo[15:0]);
            end
            bsc_pkg::ST_P_NUM: begin
                mul_req.a = numer;
                mul_req.b = bsc_pkg::NUM_SCALE;
            end
            bsc_pkg::ST_P_F: begin
                mul_req.a = bsc_pkg::sext16(r_pcal_last);
                mul_req.b = e;
            end
            bsc_pkg::ST_P_G: begin
                mul_req.a = r_y;
                mul_req.b = e;
            end
            bsc_pkg::ST_P_H: begin
                mul_req.a = bsc_pkg::sext16(r_pcal_hi[63:48]);
                mul_req.b = r_p;
            end
            default: is_mul = 1'b0;
        endcase
        mul_req.start = is_mul && !r_launched;
        div_req.start = (r_state == bsc_pkg::ST_P_DIV) && !r_launched;
        div_req.num   = r_x[DW-1] ? (DW'(0) - r_x) : r_x;
        div_req.den   = r_y[DW-1] ? (DW'(0) - r_y) : r_y;
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsc_pkg::ST_IDLE;
            r_launched  <= 1'b0;
            r_ov        <= 1'b0;
            r_fine      <= '0;
            r_tcal      <= '0;
            r_pcal_lo   <= '0;
            r_pcal_hi   <= '0;
            r_pcal_last <= '0;
        end else begin
            r_state <= n_state;
            if (mul_req.start || div_req.start) begin
                r_launched <= 1'b1;
            end else if (mul_done || div_done) begin
                r_launched <= 1'b0;
            end
            if (r_state == bsc_pkg::ST_T_E && mul_done) begin
                r_fine <= fine_n;
            end
            if (r_state == bsc_pkg::ST_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bsc_pkg::CFG_TEMP_CAL:   r_tcal      <= i_cfg_data[bsc_pkg::TCAL_W-1:0];
                    bsc_pkg::CFG_PRESS_LOW:  r_pcal_lo   <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_HIGH: r_pcal_hi   <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_LAST: r_pcal_last <= i_cfg_data[bsc_pkg::CAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == bsc_pkg::ST_IDLE && i_valid) begin
            r_adc <= i_raw_reading[bsc_pkg::RAW_W-1 -: RAW_BITS];
            r_op  <= i_opcode;
            r_rz  <= 1'b0;
            r_rt  <= '0;
        end
        if (mul_done) begin
            case (r_state)
                bsc_pkg::ST_T_A:   r_x <= DW'(TW'($signed(pr[TW-1:0]) >>> 11));
                bsc_pkg::ST_T_D:   r_y <= DW'(TW'($signed(pr[TW-1:0]) >>> 12));
                bsc_pkg::ST_T_E:   r_rt <= temp_n;
                bsc_pkg::ST_P_S:   r_s <= pr;
                bsc_pkg::ST_P_V2A: r_x <= pr;
                bsc_pkg::ST_P_T: begin
                    r_x <= r_x + (pr << 17) + (bsc_pkg::sext16(r_pcal_lo[63:48]) << 35);
                end
                bsc_pkg::ST_P_U:   r_y <= DW'($signed(pr) >>> 8);
                bsc_pkg::ST_P_W:   r_y <= r_y + (pr << 12) + bsc_pkg::V1_BIAS;
                bsc_pkg::ST_P_V1C: begin
                    r_y  <= v1c;
                    r_rz <= (v1c == '0);
                end
                bsc_pkg::ST_P_NUM: r_x <= pr;
                bsc_pkg::ST_P_F:   r_y <= pr;
                bsc_pkg::ST_P_G:   r_y <= DW'($signed(pr) >>> 25);
                bsc_pkg::ST_P_H:   r_x <= DW'($signed(pr) >>> 19);
                default: ;
            endcase
        end
        if (r_state == bsc_pkg::ST_P_DIV && div_done) begin
            r_p <= qs;
        end
        if (r_state == bsc_pkg::ST_P_SUM) begin
            r_x <= pfin;
        end
        if (r_state == bsc_pkg::ST_OUT && (!r_ov || i_ready)) begin
            r_o_temp  <= r_op ? '0 : r_rt;
            r_o_press <= (r_op && !r_rz) ? TW'($signed(p_biased) >>> 8) : '0;
            r_o_zd    <= r_op && r_rz;
        end
    end

    assign o_ready             = (r_state == bsc_pkg::ST_IDLE);
    assign o_valid             = r_ov;
    assign o_temperature_centi = $signed(r_o_temp);
    assign o_pressure_pa       = r_o_press;
    assign o_zero_divisor      = r_o_zd;

    a_mul_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_launched)
        else $error("multiplier finished with no step waiting");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == bsc_pkg::ST_P_DIV))
        else $error("divider finished outside the divide step");

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("both units started together");

    a_zd_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |-> (o_pressure_pa == '0 && o_temperature_centi == '0))
        else $error("zero divisor item carries a value");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_temperature_centi == '0 || (o_pressure_pa == '0 && !o_zero_divisor)))
        else $error("item mixes temperature and pressure fields");

endmodule

// ===== dv/bsc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_tb_pkg
// Opcode names shared by the compensation testbench and its checker.
// ----------------------------------------------------------------------------
package bsc_tb_pkg;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

endpackage

// ===== dv/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker
// Watches the configuration port and both item channels of the compensation
// block, predicts each result from its own calibration copy and fine
// temperature, and compares results in order against the predictions.
// ----------------------------------------------------------------------------
module bsc_checker
    import bsc_pkg::*;
    import bsc_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DW-1:0]         i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_in_ready,
    input  logic                  i_opcode,
    input  logic [RAW_W-1:0]      i_raw_reading,
    input  logic                  i_out_valid,
    input  logic                  i_ready,
    input  logic signed [TW-1:0]  i_temperature_centi,
    input  logic [TW-1:0]         i_pressure_pa,
    input  logic                  i_zero_divisor,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [TW-1:0] temp_centi;
        logic [TW-1:0]        press_pa;
        logic                 zero_div;
    } t_reading;

    logic [TCAL_W-1:0]    temp_cal;
    logic [DW-1:0]        press_lo;
    logic [DW-1:0]        press_hi;
    logic [CAL_W-1:0]     press_last;
    logic signed [TW-1:0] fine_temp;
    t_reading             expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic [DW-1:0] div_trunc(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW-1:0] ua;
        logic [DW-1:0] ub;
        logic [DW-1:0] q;
        ua = a[DW-1] ? -a : a;
        ub = b[DW-1] ? -b : b;
        q  = ua / ub;
        return (a[DW-1] != b[DW-1]) ? -q : q;
    endfunction

    function automatic logic signed [DW-1:0] word_s(input logic [CAL_W-1:0] w);
        return {{(DW-CAL_W){w[CAL_W-1]}}, w};
    endfunction

    function automatic t_reading compensate(input logic op, input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0]     mask;
        logic signed [TW-1:0] adc, t1, t2, t3, a, ta, d, dd, v1t, v2t, ft;
        logic signed [DW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [DW-1:0] v1, v2, p, e;
        t_reading             r;
        mask = RAW_W'(((32'd1 << RAW_BITS_DEF) - 32'd1) << (RAW_W - RAW_BITS_DEF));
        adc  = {12'b0, raw & mask};
        r    = '0;
        if (op == OP_TEMP) begin
            t1  = {16'b0, temp_cal[15:0]};
            t2  = {{16{temp_cal[31]}}, temp_cal[31:16]};
            t3  = {{16{temp_cal[47]}}, temp_cal[47:32]};
            a   = (adc >>> 3) - (t1 <<< 1);
            ta  = a * t2;
            v1t = ta >>> 11;
            d   = (adc >>> 4) - t1;
            dd  = d * d;
            dd  = dd >>> 12;
            dd  = dd * t3;
            v2t = dd >>> 14;
            fine_temp = v1t + v2t;
            ft  = fine_temp * 5 + 128;
            r.temp_centi = ft >>> 8;
        end else begin
            p1 = {48'b0, press_lo[15:0]};
            p2 = word_s(press_lo[31:16]);
            p3 = word_s(press_lo[47:32]);
            p4 = word_s(press_lo[63:48]);
            p5 = word_s(press_hi[15:0]);
            p6 = word_s(press_hi[31:16]);
            p7 = word_s(press_hi[47:32]);
            p8 = word_s(press_hi[63:48]);
            p9 = word_s(press_last);
            v1 = {{32{fine_temp[31]}}, fine_temp};
            v1 = v1 - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            p  = v1 * v1 * p3;
            v1 = (p >>> 8) + ((v1 * p2) <<< 12);
            p  = ((64'sd1 <<< 47) + v1) * p1;
            v1 = p >>> 33;
            if (v1 == 0) begin
                r.zero_div = 1'b1;
            end else begin
                p  = 64'sd1048576 - adc;
                p  = ((p <<< 31) - v2) * 64'sd3125;
                p  = div_trunc(p, v1);
                e  = p >>> 13;
                v1 = p9 * e * e;
                v1 = v1 >>> 25;
                v2 = p8 * p;
                v2 = v2 >>> 19;
                e  = p + v1 + v2;
                p  = (e >>> 8) + (p7 <<< 4);
                e  = div_trunc(p, 64'd256);
                r.press_pa = e[TW-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            temp_cal     <= '0;
            press_lo     <= '0;
            press_hi     <= '0;
            press_last   <= '0;
            fine_temp    = '0;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEMP_CAL:   temp_cal   <= i_cfg_data[TCAL_W-1:0];
                    CFG_PRESS_LOW:  press_lo   <= i_cfg_data;
                    CFG_PRESS_HIGH: press_hi   <= i_cfg_data;
                    CFG_PRESS_LAST: press_last <= i_cfg_data[CAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                expected_q.push_back(compensate(i_opcode, i_raw_reading));
            if (i_out_valid && i_ready) begin
                got = '{i_temperature_centi, i_pressure_pa, i_zero_divisor};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result temp=%0d press=%0d zdiv=%0b",
                             $time, got.temp_centi, got.press_pa, got.zero_div);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected temp=%0d press=%0d zdiv=%0b",
                                 $time, want.temp_centi, want.press_pa, want.zero_div);
                        $display("%0t:          actual   temp=%0d press=%0d zdiv=%0b",
                                 $time, got.temp_centi, got.press_pa, got.zero_div);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/barometric_sensor_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_tb
// Drives calibration phases and temperature and pressure items into the
// compensation block under varied idling and back-pressure; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_tb;
    import bsc_pkg::*;
    import bsc_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT    = 3_000_000;
    localparam int HOLD_LEN = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TEMP_CAL;
    logic [DW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_opcode = OP_TEMP;
    logic [RAW_W-1:0]     i_raw_reading = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [TW-1:0] o_temperature_centi;
    logic [TW-1:0]        o_pressure_pa;
    logic                 o_zero_divisor;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 hold_req = 1'b0;
    logic                 hold_taken = 1'b0;
    int                   hold_cycles = 0;
    int                   cycle_count = 0;

    always #5 i_clk = ~i_clk;

    barometric_sensor_compensation u_dut (.*);

    bsc_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_ready(o_ready), .i_opcode, .i_raw_reading,
        .i_out_valid(o_valid), .i_ready, .i_temperature_centi(o_temperature_centi),
        .i_pressure_pa(o_pressure_pa), .i_zero_divisor(o_zero_divisor),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= HOLD_LEN;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("barometric_sensor_compensation_tb: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_raw_reading <= raw;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and let every result drain before touching calibration
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [15:0] p9);
        drain();
        write_cal(CFG_TEMP_CAL, {16'($urandom), t});
        write_cal(CFG_PRESS_LOW, lo);
        write_cal(CFG_PRESS_HIGH, hi);
        write_cal(CFG_PRESS_LAST, {48'($urandom), p9});
    endtask

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return RAW_W'(1) << $urandom_range(RAW_W - 1);
            3, 4:    return RAW_W'($urandom_range(600000, 300000));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic random_items(input int n);
        repeat (n) begin
            send_item($urandom_range(1) ? OP_PRESS : OP_TEMP, pick_raw());
        end
    endtask

    localparam logic [47:0] T_TYP  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] PL_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] PH_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [15:0] P9_TYP = 16'd6000;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero calibration after reset: pressure divisor is zero
        send_item(OP_PRESS, 20'h65A00);
        send_item(OP_TEMP, 20'h7EED0);
        send_item(OP_PRESS, '1);

        load_cal(T_TYP, PL_TYP, PH_TYP, P9_TYP);
        send_item(OP_PRESS, 20'd415148);
        send_item(OP_TEMP, 20'd519888);
        send_item(OP_PRESS, 20'd415148);
        send_item(OP_PRESS, '0);
        send_item(OP_PRESS, '1);
        send_item(OP_TEMP, '0);
        send_item(OP_TEMP, '1);
        send_item(OP_PRESS, 20'h55555);
        send_item(OP_TEMP, 20'hAAAAA);

        // Extreme words
        load_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                 {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
        send_item(OP_TEMP, '1);
        send_item(OP_PRESS, '0);
        send_item(OP_TEMP, '0);
        send_item(OP_PRESS, '1);
        load_cal('1, '1, '1, '1);
        send_item(OP_TEMP, 20'd519888);
        send_item(OP_PRESS, 20'd1);
        send_item(OP_PRESS, 20'hFFFFE);

        // Long receiver hold-off while the sender keeps offering items
        load_cal(T_TYP, PL_TYP, PH_TYP, P9_TYP);
        hold_req <= 1'b1;
        random_items(8);

        send_idle_pct = 9;
        recv_idle_pct = 63;
        random_items(120);
        load_cal(48'($urandom) ^ (48'($urandom) << 32), {$urandom, $urandom},
                 {$urandom, $urandom}, 16'($urandom));
        random_items(40);

        send_idle_pct = 63;
        recv_idle_pct = 9;
        load_cal(T_TYP, PL_TYP, PH_TYP, P9_TYP);
        random_items(100);
        load_cal(T_TYP, {PL_TYP[63:16], 16'd0}, PH_TYP, P9_TYP);
        random_items(15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_cal(48'($urandom) ^ (48'($urandom) << 32), {$urandom, $urandom},
                 {$urandom, $urandom}, 16'($urandom));
        random_items(60);
        load_cal(T_TYP, PL_TYP, PH_TYP, P9_TYP);
        random_items(100);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("barometric_sensor_compensation_tb: PASS");
        end else begin
            $display("barometric_sensor_compensation_tb: FAIL");
        end
        $finish;
    end

endmodule
